// ===== hdl/bhba_pkg.sv =====
// Shared types and constants of the bitmap heap block allocator.
package bhba_pkg;

  localparam int MAX_BLOCKS_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int PAGE_BYTES       = 4096;
  localparam logic [7:0] HEADER_TAG = 8'd5;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_FORMAT = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;

  localparam logic [2:0] REG_R0_BASE  = 3'd0;
  localparam logic [2:0] REG_R0_BYTES = 3'd1;
  localparam logic [2:0] REG_R0_BSIZE = 3'd2;
  localparam logic [2:0] REG_R1_BASE  = 3'd3;
  localparam logic [2:0] REG_R1_BYTES = 3'd4;
  localparam logic [2:0] REG_R1_BSIZE = 3'd5;

  localparam logic [16:0] R0_BSIZE_RST = 17'd16;
  localparam logic [16:0] R1_BSIZE_RST = 17'd4096;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] request_bytes;
    logic [47:0] address;
    logic        region;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] result_address;
    logic        hit_region;
    logic [12:0] used_count;
  } rsp_t;

endpackage

// ===== hdl/bhba_tag_ram.sv =====
// Tag memory: one write port, one read port, registered read data.
module bhba_tag_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bhba_div.sv =====
// Restoring divider, one quotient bit per cycle.
module bhba_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [16:0] divisor,
  output logic [47:0] quotient,
  output logic        done
);

  logic [47:0] num;
  logic [16:0] den;
  logic [17:0] rem;
  logic [5:0]  count;
  logic        busy;
  logic [18:0] trial;
  logic [17:0] shifted;

  assign shifted = {rem[16:0], num[47]};
  assign trial   = {1'b0, shifted} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'd47;
        num   <= dividend;
        den   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        if (trial[18]) begin
          rem      <= shifted;
          quotient <= {quotient[46:0], 1'b0};
        end else begin
          rem      <= trial[17:0];
          quotient <= {quotient[46:0], 1'b1};
        end
        num <= {num[46:0], 1'b0};
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 6'd1;
        end
      end
    end
  end

endmodule

// ===== hdl/bitmap_heap_block_allocator.sv =====
// Format sweeps the map of its region; allocate scans the blocks of each region tried
// (one tag per cycle from the tag memory read port) and writes the run; free clears it.
// Format, and an allocate or free past its check, use two divisions on the shared divider.
// One request at a time; a finished result waits in the output register.
// Reset (synchronous, rst high) resets registers, clears counts and ready flags; the tag memory
// is not cleared and a region reads as absent until formatted.
module bitmap_heap_block_allocator #(
  parameter int MAX_BLOCKS   = bhba_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = bhba_pkg::HEADER_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bhba_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bhba_pkg::rsp_t rsp,
  input  logic           cfg_write,
  input  logic [2:0]     cfg_index,
  input  logic [47:0]    cfg_data
);
  import bhba_pkg::*;

  localparam int NW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = $clog2(2 * MAX_BLOCKS);
  localparam int PW = NW + 17;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DWAIT  = 5'd1;
  localparam logic [4:0] S_GOTN   = 5'd2;
  localparam logic [4:0] S_FHDR   = 5'd3;
  localparam logic [4:0] S_FSWEEP = 5'd4;
  localparam logic [4:0] S_AMUL   = 5'd5;
  localparam logic [4:0] S_ACHK   = 5'd6;
  localparam logic [4:0] S_ASCAN0 = 5'd7;
  localparam logic [4:0] S_SCAN   = 5'd8;
  localparam logic [4:0] S_IDSEL  = 5'd9;
  localparam logic [4:0] S_AWR    = 5'd10;
  localparam logic [4:0] S_AADR   = 5'd11;
  localparam logic [4:0] S_FCHK   = 5'd12;
  localparam logic [4:0] S_FBI    = 5'd13;
  localparam logic [4:0] S_FRD    = 5'd14;
  localparam logic [4:0] S_FID    = 5'd15;
  localparam logic [4:0] S_FRUN   = 5'd16;
  localparam logic [4:0] S_DONE   = 5'd17;
  localparam logic [4:0] S_DSTART = 5'd18;

  logic [47:0] base  [2];
  logic [31:0] bytes [2];
  logic [16:0] bsize [2];
  logic [NW-1:0] used [2];
  logic [1:0]    ready;

  logic [4:0]  state;
  logic [4:0]  ret;
  logic [1:0]  op;
  logic [31:0] size;
  logic [47:0] addr;
  logic        r;
  logic [NW-1:0] n;
  logic [NW-1:0] hdr;
  logic [32:0]   need;
  logic [NW-1:0] idx;
  logic [NW-1:0] scan_i;
  logic [NW-1:0] chk_i;
  logic          chk_valid;
  logic [NW-1:0] cnt;
  logic [NW-1:0] start;
  logic [7:0]    last;
  logic [7:0]    prev;
  logic [7:0]    id;
  logic          nxt_ok;
  logic [PW-1:0] prod;
  rsp_t          res;

  logic        div_start;
  logic [47:0] div_a;
  logic [47:0] div_q;
  logic        div_done;

  logic [16:0]   bs_cur;
  logic [31:0]   data_cur;
  logic [NW-1:0] n_sat;
  logic [63:0]   avail;
  logic          alloc_ok;
  logic          free_hit;
  logic [48:0]   end_addr;
  logic [NW-1:0] used_dec;
  logic [7:0]    tag_rd;
  logic [7:0]    nxt_tag;
  logic          we;
  logic [NW-1:0] widx;
  logic [7:0]    wval;
  logic [NW-1:0] ridx;

  function automatic logic [AW-1:0] map_idx(input logic [NW-1:0] i, input logic rs);
    logic [NW-1:0] j;
    j = (i >= NW'(MAX_BLOCKS)) ? i - NW'(MAX_BLOCKS) : i;
    return rs ? AW'(MAX_BLOCKS) + AW'(j) : AW'(j);
  endfunction

  function automatic logic [7:0] pick_id(input logic [7:0] p, input logic [7:0] nx);
    logic [7:0] c;
    c = p + 8'd1;
    if (c == nx || c == 8'd0) c = c + 8'd1;
    if (c == nx || c == 8'd0) c = c + 8'd1;
    return c;
  endfunction

  assign bs_cur   = (bsize[r] == '0) ? 17'd1 : bsize[r];
  assign data_cur = (bytes[r] >= 32'(HEADER_BYTES)) ? bytes[r] - 32'(HEADER_BYTES) : '0;
  assign n_sat    = (div_q > 48'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS) : div_q[NW-1:0];
  assign avail    = (64'(data_cur) > 64'(prod)) ? 64'(data_cur) - 64'(prod) : '0;
  assign alloc_ok = ready[r] && (avail >= 64'(size)) &&
                    ((size[11:0] == '0) == (bs_cur == 17'(PAGE_BYTES)));
  assign end_addr = 49'(base[r]) + 49'(HEADER_BYTES) + 49'(data_cur);
  assign free_hit = ready[r] && (addr > base[r]) && (49'(addr) < end_addr);
  assign used_dec = (used[r] > cnt) ? used[r] - cnt : '0;
  assign nxt_tag  = nxt_ok ? tag_rd : 8'd0;
  assign req_stall = (state != S_IDLE);
  assign div_start = (state == S_DSTART);

  always_comb begin
    we   = 1'b0;
    widx = idx;
    wval = 8'd0;
    ridx = idx;
    case (state)
      S_FSWEEP: begin
        we   = (idx < n);
        wval = (idx < hdr) ? HEADER_TAG : 8'd0;
      end
      S_SCAN: ridx = scan_i;
      S_AWR: begin
        we   = 1'b1;
        wval = id;
      end
      S_FID: begin
        we   = (tag_rd != 8'd0);
        ridx = idx + NW'(1);
      end
      S_FRUN: begin
        we   = (idx < n) && (tag_rd == id);
        ridx = idx + NW'(1);
      end
      default: ;
    endcase
  end

  bhba_tag_ram #(
    .DEPTH(2 * MAX_BLOCKS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(map_idx(widx, r)),
    .wdata(wval),
    .raddr(map_idx(ridx, r)),
    .rdata(tag_rd)
  );

  bhba_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_a),
    .divisor (bs_cur),
    .quotient(div_q),
    .done    (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base[0]  <= '0;
      base[1]  <= '0;
      bytes[0] <= '0;
      bytes[1] <= '0;
      bsize[0] <= R0_BSIZE_RST;
      bsize[1] <= R1_BSIZE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_R0_BASE:  base[0]  <= cfg_data;
        REG_R0_BYTES: bytes[0] <= cfg_data[31:0];
        REG_R0_BSIZE: bsize[0] <= cfg_data[16:0];
        REG_R1_BASE:  base[1]  <= cfg_data;
        REG_R1_BYTES: bytes[1] <= cfg_data[31:0];
        REG_R1_BSIZE: bsize[1] <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used[0]   <= '0;
      used[1]   <= '0;
      ready     <= '0;
      rsp_valid <= 1'b0;
      res       <= '0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op   <= req.op;
            size <= req.request_bytes;
            addr <= req.address;
            case (req.op)
              OP_FORMAT: begin
                r     <= req.region;
                div_a <= 48'((bytes[req.region] >= 32'(HEADER_BYTES)) ?
                             bytes[req.region] - 32'(HEADER_BYTES) : 32'd0);
                ret   <= S_GOTN;
                state <= S_DSTART;
              end
              OP_ALLOC: begin
                r <= 1'b1;
                if (req.request_bytes == '0) begin
                  res.status <= ST_NO_SPACE;
                  state      <= S_DONE;
                end else begin
                  state <= S_AMUL;
                end
              end
              OP_FREE: begin
                r     <= 1'b1;
                state <= S_FCHK;
              end
              default: ;
            endcase
          end
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            state <= ret;
          end
        end
        S_GOTN: begin
          n     <= n_sat;
          state <= S_DSTART;
          case (op)
            OP_FORMAT: begin
              div_a <= 48'(n_sat) + 48'(HEADER_BYTES) + 48'(bs_cur) - 48'd1;
              ret   <= S_FHDR;
            end
            OP_ALLOC: begin
              div_a <= 48'(size) + 48'(bs_cur) - 48'd1;
              ret   <= S_ASCAN0;
            end
            default: begin
              div_a <= addr - base[r];
              ret   <= S_FBI;
            end
          endcase
        end
        S_FHDR: begin
          hdr   <= (div_q > 48'(n)) ? n : div_q[NW-1:0];
          idx   <= '0;
          state <= S_FSWEEP;
        end
        S_FSWEEP: begin
          if (idx < n) begin
            idx <= idx + NW'(1);
          end else begin
            used[r]        <= hdr;
            ready[r]       <= 1'b1;
            res.hit_region <= r;
            res.used_count <= 13'(hdr);
            state          <= S_DONE;
          end
        end
        S_AMUL: begin
          prod  <= PW'(used[r] * bs_cur);
          state <= S_ACHK;
        end
        S_ACHK: begin
          if (alloc_ok) begin
            div_a <= 48'(data_cur);
            ret   <= S_GOTN;
            state <= S_DSTART;
          end else if (r) begin
            r     <= 1'b0;
            state <= S_AMUL;
          end else begin
            res.status <= ST_NO_SPACE;
            state      <= S_DONE;
          end
        end
        S_ASCAN0: begin
          need      <= div_q[32:0];
          scan_i    <= '0;
          chk_valid <= 1'b0;
          cnt       <= '0;
          last      <= 8'd0;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          chk_valid <= (scan_i < n);
          chk_i     <= scan_i;
          if (scan_i < n) begin
            scan_i <= scan_i + NW'(1);
          end
          if (chk_valid) begin
            last <= tag_rd;
            if (tag_rd == 8'd0) begin
              if (cnt == '0) begin
                start <= chk_i;
                prev  <= last;
              end
              cnt <= cnt + NW'(1);
              if (33'(cnt) + 33'd1 == need) begin
                nxt_ok <= (scan_i < n);
                state  <= S_IDSEL;
              end
            end else begin
              cnt <= '0;
            end
          end else if (scan_i >= n) begin
            if (r) begin
              r     <= 1'b0;
              state <= S_AMUL;
            end else begin
              res.status <= ST_NO_SPACE;
              state      <= S_DONE;
            end
          end
        end
        S_IDSEL: begin
          id    <= pick_id(prev, nxt_tag);
          idx   <= start;
          cnt   <= '0;
          state <= S_AWR;
        end
        S_AWR: begin
          idx <= idx + NW'(1);
          cnt <= cnt + NW'(1);
          if (33'(cnt) + 33'd1 == need) begin
            used[r] <= used[r] + NW'(need);
            prod    <= PW'(start * bs_cur);
            state   <= S_AADR;
          end
        end
        S_AADR: begin
          res.result_address <= base[r] + 48'(prod);
          res.hit_region     <= r;
          res.used_count     <= 13'(used[r]);
          state              <= S_DONE;
        end
        S_FCHK: begin
          if (free_hit) begin
            div_a <= 48'(data_cur);
            ret   <= S_GOTN;
            state <= S_DSTART;
          end else if (r) begin
            r <= 1'b0;
          end else begin
            res.status <= ST_BAD_ADDR;
            state      <= S_DONE;
          end
        end
        S_FBI: begin
          res.hit_region <= r;
          if (div_q >= 48'(n)) begin
            res.status     <= ST_BAD_ADDR;
            res.used_count <= 13'(used[r]);
            state          <= S_DONE;
          end else begin
            idx   <= div_q[NW-1:0];
            state <= S_FRD;
          end
        end
        S_FRD: state <= S_FID;
        S_FID: begin
          if (tag_rd == 8'd0) begin
            res.status     <= ST_BAD_ADDR;
            res.used_count <= 13'(used[r]);
            state          <= S_DONE;
          end else begin
            id    <= tag_rd;
            cnt   <= NW'(1);
            idx   <= idx + NW'(1);
            state <= S_FRUN;
          end
        end
        S_FRUN: begin
          if (idx < n && tag_rd == id) begin
            cnt <= cnt + NW'(1);
            idx <= idx + NW'(1);
          end else begin
            used[r]        <= used_dec;
            res.used_count <= 13'(used_dec);
            state          <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res;
            res       <= '0;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used[0] <= NW'(MAX_BLOCKS) && used[1] <= NW'(MAX_BLOCKS))
    else $error("used block count beyond map size");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> cnt <= n)
    else $error("free run longer than region");

  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_AWR |-> id != 8'd0 && id != prev)
    else $error("run id clashes with neighbor or is zero");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_DWAIT) |-> $past(div_start))
    else $error("divider wait entered without start");

endmodule

// ===== tb/bhba_checker.sv =====
// Response checker for the bitmap heap block allocator: tracks config, predicts and compares.
module bhba_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  bhba_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  bhba_pkg::rsp_t rsp,
  input  logic           cfg_write,
  input  logic [2:0]     cfg_index,
  input  logic [47:0]    cfg_data,
  output int             fail_count,
  output int             pending,
  output int             checked
);
  import bhba_pkg::*;

  localparam int NBLK = MAX_BLOCKS_DEF;
  localparam longint unsigned HDR = HEADER_BYTES_DEF;

  logic [7:0]      tag_map [0:2*NBLK-1];
  longint unsigned blocks_used [2];
  bit              ready [2];
  logic [47:0]     base_reg [2];
  logic [31:0]     bytes_reg [2];
  logic [16:0]     bsize_reg [2];
  rsp_t            expected_q [$];

  assign pending = expected_q.size();

  function automatic longint unsigned bsize_of(int r);
    return (bsize_reg[r] == 0) ? 1 : longint'(bsize_reg[r]);
  endfunction

  function automatic longint unsigned data_of(int r);
    return (bytes_reg[r] >= HDR) ? longint'(bytes_reg[r]) - HDR : 0;
  endfunction

  function automatic longint unsigned blocks_of(int r);
    longint unsigned n;
    n = data_of(r) / bsize_of(r);
    return (n > NBLK) ? NBLK : n;
  endfunction

  function automatic void format_region(int r);
    longint unsigned n, bs, hdr;
    n = blocks_of(r);
    bs = bsize_of(r);
    hdr = (n + HDR + bs - 1) / bs;
    if (hdr > n) hdr = n;
    for (longint unsigned i = 0; i < n; i++)
      tag_map[r*NBLK + i] = (i < hdr) ? HEADER_TAG : 8'd0;
    blocks_used[r] = hdr;
    ready[r] = 1;
  endfunction

  function automatic bit carve_run(int r, longint unsigned size, output logic [47:0] addr);
    longint unsigned bs, data, n, taken, avail, need, j;
    logic [7:0] prev, next, id;
    bs = bsize_of(r);
    data = data_of(r);
    n = blocks_of(r);
    addr = '0;
    if (!ready[r]) return 0;
    taken = blocks_used[r] * bs;
    avail = (data > taken) ? data - taken : 0;
    if (avail < size) return 0;
    if (((size % PAGE_BYTES) == 0) != (bs == PAGE_BYTES)) return 0;
    need = (size + bs - 1) / bs;
    for (longint unsigned i = 0; i < n; i++) begin
      if (tag_map[r*NBLK + i] != 0) continue;
      j = 0;
      while (j < need && i + j < n && tag_map[r*NBLK + i + j] == 0) j++;
      if (j != need) begin
        i += j - 1;
        continue;
      end
      prev = (i > 0) ? tag_map[r*NBLK + i - 1] : 8'd0;
      next = (i + j < n) ? tag_map[r*NBLK + i + j] : 8'd0;
      id = prev + 8'd1;
      while (id == next || id == 0) id = id + 8'd1;
      for (j = 0; j < need; j++) tag_map[r*NBLK + i + j] = id;
      blocks_used[r] += need;
      addr = 48'(longint'(base_reg[r]) + i * bs);
      return 1;
    end
    return 0;
  endfunction

  function automatic rsp_t serve_request(req_t q);
    rsp_t o;
    logic [47:0] a;
    longint unsigned base, n, bi, i;
    logic [7:0] id;
    int r;
    o = '0;
    if (q.op == OP_FORMAT) begin
      r = q.region;
      format_region(r);
      o.hit_region = q.region;
      o.used_count = 13'(blocks_used[r]);
      return o;
    end
    if (q.op == OP_ALLOC) begin
      if (q.request_bytes != 0)
        for (int k = 0; k < 2; k++) begin
          r = 1 - k;
          if (carve_run(r, longint'(q.request_bytes), a)) begin
            o.result_address = a;
            o.hit_region = 1'(r);
            o.used_count = 13'(blocks_used[r]);
            return o;
          end
        end
      o.status = ST_NO_SPACE;
      return o;
    end
    for (int k = 0; k < 2; k++) begin
      r = 1 - k;
      base = base_reg[r];
      if (!ready[r] || q.address <= base || longint'(q.address) >= base + HDR + data_of(r))
        continue;
      n = blocks_of(r);
      bi = (longint'(q.address) - base) / bsize_of(r);
      o.hit_region = 1'(r);
      if (bi >= n || tag_map[r*NBLK + bi] == 0) begin
        o.status = ST_BAD_ADDR;
        o.used_count = 13'(blocks_used[r]);
        return o;
      end
      id = tag_map[r*NBLK + bi];
      for (i = bi; i < n && tag_map[r*NBLK + i] == id; i++) tag_map[r*NBLK + i] = 8'd0;
      blocks_used[r] = (blocks_used[r] > i - bi) ? blocks_used[r] - (i - bi) : 0;
      o.used_count = 13'(blocks_used[r]);
      return o;
    end
    o.status = ST_BAD_ADDR;
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      fail_count <= 0;
      checked <= 0;
      expected_q.delete();
      blocks_used[0] = 0;
      blocks_used[1] = 0;
      ready[0] = 0;
      ready[1] = 0;
      base_reg[0] = '0;
      base_reg[1] = '0;
      bytes_reg[0] = '0;
      bytes_reg[1] = '0;
      bsize_reg[0] = R0_BSIZE_RST;
      bsize_reg[1] = R1_BSIZE_RST;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_R0_BASE:  base_reg[0] = cfg_data;
          REG_R0_BYTES: bytes_reg[0] = cfg_data[31:0];
          REG_R0_BSIZE: bsize_reg[0] = cfg_data[16:0];
          REG_R1_BASE:  base_reg[1] = cfg_data;
          REG_R1_BYTES: bytes_reg[1] = cfg_data[31:0];
          REG_R1_BSIZE: bsize_reg[1] = cfg_data[16:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall && req.op != OP_NOP)
        expected_q.push_back(serve_request(req));
      if (rsp_valid && !rsp_stall) begin
        checked <= checked + 1;
        if (expected_q.size() == 0) begin
          $error("response beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e != rsp) fail_count <= fail_count + 1;
          if (e.status != rsp.status)
            $error("status expected %0d got %0d", e.status, rsp.status);
          if (e.result_address != rsp.result_address)
            $error("result_address expected %0h got %0h", e.result_address,
                   rsp.result_address);
          if (e.hit_region != rsp.hit_region)
            $error("hit_region expected %0d got %0d", e.hit_region, rsp.hit_region);
          if (e.used_count != rsp.used_count)
            $error("used_count expected %0d got %0d", e.used_count, rsp.used_count);
        end
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the bitmap heap block allocator: stimulus, stalls and verdict.
module tb;
  import bhba_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        req_valid = 0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 0;
  rsp_t        rsp;
  logic        cfg_write = 0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  int          fail_count, pending, checked;

  logic [47:0] base_now [2];
  logic [16:0] bsize_now [2];
  logic [47:0] live_addrs [$];
  int          sent = 0;
  int          settings = 0;
  int          hold_left = 0;
  bit          held = 0;
  int          mode_left = 0;
  bit          quiet = 0;

  bitmap_heap_block_allocator dut (.*);

  bhba_checker u_chk (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    #40000000;
    $display("tb NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rsp_valid && !rsp_stall && rsp.status == ST_DONE && rsp.result_address != 0)
      live_addrs.push_back(rsp.result_address);
    if (!held && checked >= 60) begin
      held = 1;
      hold_left = 3000;
    end
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 80);
      quiet = ($urandom_range(0, 2) == 0);
    end else mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1;
    end else rsp_stall <= !quiet && ($urandom_range(0, 2) == 0);
  end

  task automatic push_beat(req_t q);
    req <= q;
    req_valid <= 1;
    do @(posedge clk); while (req_stall);
    if (q.op != OP_NOP) sent++;
  endtask

  task automatic pause(int n);
    req_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    pause(1);
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  function automatic req_t make_op(logic [1:0] op, logic [31:0] sz, logic [47:0] a, bit r);
    req_t q;
    q.op = op;
    q.request_bytes = sz;
    q.address = a;
    q.region = r;
    return q;
  endfunction

  task automatic load_regions(logic [47:0] b0, logic [31:0] n0, logic [16:0] s0,
                              logic [47:0] b1, logic [31:0] n1, logic [16:0] s1);
    logic [47:0] vals [6];
    vals = '{b0, 48'(n0), 48'(s0), b1, 48'(n1), 48'(s1)};
    base_now = '{b0, b1};
    bsize_now = '{s0, s1};
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 0;
    live_addrs.delete();
    settings++;
  endtask

  function automatic req_t random_beat();
    int pick, r;
    logic [31:0] bs;
    logic [47:0] a;
    pick = $urandom_range(0, 99);
    r = $urandom_range(0, 1);
    bs = (bsize_now[r] == 0) ? 1 : 32'(bsize_now[r]);
    if (pick < 60) begin
      if (pick < 5) return make_op(OP_ALLOC, $urandom(), '0, 0);
      if (bs == PAGE_BYTES || pick < 10)
        return make_op(OP_ALLOC, PAGE_BYTES * $urandom_range(1, 4), '0, 0);
      return make_op(OP_ALLOC, $urandom_range(1, 5) * bs - $urandom_range(0, bs - 1), '0, 0);
    end
    if (pick < 92) begin
      if (live_addrs.size() != 0 && pick < 82) begin
        int k;
        k = $urandom_range(0, live_addrs.size() - 1);
        a = live_addrs[k] + $urandom_range(0, bs - 1);
        if ($urandom_range(0, 2) != 0) live_addrs.delete(k);
      end else if (pick < 87) a = base_now[r] + $urandom_range(0, 24 + 8 * bs);
      else a = {$urandom(), $urandom()};
      return make_op(OP_FREE, $urandom(), a, 0);
    end
    if (pick < 96) return make_op(OP_FORMAT, $urandom(), {$urandom(), $urandom()}, 1'(r));
    return make_op(OP_NOP, $urandom(), {$urandom(), $urandom()}, 1'(r));
  endfunction

  task automatic random_run(int n);
    int left;
    left = n;
    while (left > 0) begin
      repeat ($urandom_range(1, 8)) begin
        if (left > 0) begin
          push_beat(random_beat());
          left--;
        end
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 5));
    end
  endtask

  task automatic format_both();
    push_beat(make_op(OP_FORMAT, '0, '0, 0));
    push_beat(make_op(OP_FORMAT, '1, '1, 1));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    base_now = '{48'd0, 48'd0};
    bsize_now = '{R0_BSIZE_RST, R1_BSIZE_RST};

    push_beat(make_op(OP_ALLOC, 32'd16, '0, 0));
    push_beat(make_op(OP_FREE, '0, 48'h1000, 0));
    drain();
    load_regions(48'h1000, 24 + 16 * 40, 17'd16, 48'h100000, 24 + 4096 * 12, 17'd4096);
    format_both();
    push_beat(make_op(OP_ALLOC, 32'd0, '0, 0));
    push_beat(make_op(OP_ALLOC, 32'hFFFF_FFFF, '0, 0));
    push_beat(make_op(OP_ALLOC, 32'd20, '0, 0));
    push_beat(make_op(OP_ALLOC, 32'd4096, '0, 0));
    push_beat(make_op(OP_ALLOC, 32'd8192, '0, 0));
    push_beat(make_op(OP_ALLOC, 32'd1, '0, 0));
    push_beat(make_op(OP_FREE, '0, 48'h1000, 0));
    push_beat(make_op(OP_FREE, '0, 48'h1001, 0));
    push_beat(make_op(OP_FREE, '0, 48'h1001, 0));
    push_beat(make_op(OP_FREE, '0, 48'h0, 0));
    push_beat(make_op(OP_FREE, '0, 48'hFFFF_FFFF_FFFF, 0));
    push_beat(make_op(OP_FREE, '0, 48'h100000 + 24 + 4096 * 12 - 1, 0));
    push_beat(make_op(OP_NOP, '1, '1, 1));
    push_beat(make_op(OP_ALLOC, 32'd640, '0, 0));
    push_beat(make_op(OP_ALLOC, 32'd16, '0, 0));
    random_run(25);
    drain();

    load_regions(48'hFFFF_FFFF_F000, 24 + 60, 17'd1, 48'd0, 32'd0, 17'd65536);
    format_both();
    random_run(15);
    drain();

    load_regions({$urandom(), $urandom()} & 48'hFFFF_FFFF_0000, 24 + 4096 * 20, 17'd4096,
                 48'h2000, 24 + 64 * 30, 17'd64);
    format_both();
    random_run(20);
    drain();

    load_regions(48'h10, 32'hFFFF_FFFF, 17'd65536, 48'h8000_0000_0000, 32'd100, 17'd0);
    format_both();
    random_run(15);
    drain();

    for (int p = 0; p < 2; p++) begin
      logic [16:0] s0, s1;
      s0 = ($urandom_range(0, 3) == 0) ? 17'd4096 : 17'($urandom_range(1, 200));
      s1 = ($urandom_range(0, 1) == 0) ? 17'd4096 : 17'($urandom_range(1, 200));
      load_regions({$urandom(), $urandom()}, 24 + s0 * $urandom_range(4, 60), s0,
                   {$urandom(), $urandom()}, 24 + s1 * $urandom_range(4, 60), s1);
      format_both();
      random_run(20);
      drain();
    end

    $display("covered %0d requests across %0d region settings", sent, settings);
    $display("checked %0d responses, long receiver hold applied once", checked);
    if (fail_count == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bhba_pkg.sv
hdl/bhba_tag_ram.sv
hdl/bhba_div.sv
hdl/bitmap_heap_block_allocator.sv
tb/bhba_checker.sv
tb/tb.sv
